>>> sv/bfs_multi_goal_paths_defines.svh
// Assertion helpers shared by the checker; clk and rst_n are taken from the scope of use.
`ifndef BFS_MULTI_GOAL_PATHS_DEFINES_SVH
`define BFS_MULTI_GOAL_PATHS_DEFINES_SVH

// Same-cycle implication.
`define BMGP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication.
`define BMGP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> sv/bmgp_pkg.sv
package bmgp_pkg;

    localparam int NODE_W = 10;
    localparam int DIR_W  = 3;
    localparam int CNT_W  = 11;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_WRITE_EXIT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_GOAL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 2'd3;

    localparam logic [STAT_W-1:0] STAT_ACK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SEARCH = 2'd1;
    localparam logic [STAT_W-1:0] STAT_QUERY  = 2'd2;

    typedef struct packed {
        logic accept;
        logic sweep_clr;
        logic vis_clr;
        logic seed;
        logic deq;
        logic cur_load;
        logic goal_add;
        logic goal_take;
        logic exit_start;
        logic nb_rd;
        logic nb_visit;
        logic dir_adv;
        logic out_search;
        logic out_query;
    } bmgp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd_code;
        logic             sweep_last;
        logic             vis_last;
        logic             q_empty;
        logic             goal_hit;
        logic             goal_stop;
        logic             exit_ok;
        logic             dir_last;
        logic             out_full;
    } bmgp_sts_t;

endpackage

>>> sv/bmgp_ram.sv
module bmgp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/bmgp_ctrl.sv
module bmgp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  bmgp_pkg::bmgp_sts_t   sts,
    output logic                  item_stall,
    output bmgp_pkg::bmgp_cmd_t   cmd
);

    import bmgp_pkg::*;

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_GOALWR = 4'd2;
    localparam logic [3:0] S_QRY    = 4'd3;
    localparam logic [3:0] S_VCLR   = 4'd4;
    localparam logic [3:0] S_SEED   = 4'd5;
    localparam logic [3:0] S_DEQ    = 4'd6;
    localparam logic [3:0] S_CUR    = 4'd7;
    localparam logic [3:0] S_GCHK   = 4'd8;
    localparam logic [3:0] S_EXRD   = 4'd9;
    localparam logic [3:0] S_EXCHK  = 4'd10;
    localparam logic [3:0] S_VCHK   = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign item_stall = (state_reg != S_IDLE) || sts.out_full;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                cmd.sweep_clr = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid && !item_stall)
                begin
                    cmd.accept = 1'b1;
                    case (sts.cmd_code)
                        CMD_ADD_GOAL: state_next = S_GOALWR;
                        CMD_SEARCH:   state_next = S_VCLR;
                        CMD_QUERY:    state_next = S_QRY;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_GOALWR:
            begin
                cmd.goal_add = 1'b1;
                state_next   = S_IDLE;
            end
            S_QRY:
            begin
                cmd.out_query = 1'b1;
                state_next    = S_IDLE;
            end
            S_VCLR:
            begin
                cmd.vis_clr = 1'b1;
                if (sts.vis_last)
                begin
                    state_next = S_SEED;
                end
            end
            S_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = S_DEQ;
            end
            S_DEQ:
            begin
                if (sts.q_empty)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.deq    = 1'b1;
                    state_next = S_CUR;
                end
            end
            S_CUR:
            begin
                cmd.cur_load = 1'b1;
                state_next   = S_GCHK;
            end
            S_GCHK:
            begin
                if (sts.goal_hit && sts.goal_stop)
                begin
                    cmd.goal_take = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.goal_take  = sts.goal_hit;
                    cmd.exit_start = 1'b1;
                    state_next     = S_EXRD;
                end
            end
            S_EXRD:
            begin
                state_next = S_EXCHK;
            end
            S_EXCHK:
            begin
                if (sts.exit_ok)
                begin
                    cmd.nb_rd  = 1'b1;
                    state_next = S_VCHK;
                end
                else
                begin
                    cmd.dir_adv = 1'b1;
                    state_next  = sts.dir_last ? S_DEQ : S_EXRD;
                end
            end
            S_VCHK:
            begin
                cmd.nb_visit = 1'b1;
                cmd.dir_adv  = 1'b1;
                state_next   = sts.dir_last ? S_DEQ : S_EXRD;
            end
            S_DONE:
            begin
                cmd.out_search = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/bmgp_datapath.sv
module bmgp_datapath #(
    parameter int ROOMS          = 1024,
    parameter int EXITS_PER_ROOM = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bmgp_pkg::bmgp_cmd_t           cmd,
    output bmgp_pkg::bmgp_sts_t           sts,
    input  logic                          mode,
    input  logic [bmgp_pkg::CMD_W-1:0]    command,
    input  logic [bmgp_pkg::NODE_W-1:0]   room,
    input  logic [bmgp_pkg::DIR_W-1:0]    direction,
    input  logic [bmgp_pkg::NODE_W-1:0]   target,
    input  logic                          exit_present,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [bmgp_pkg::STAT_W-1:0]   status,
    output logic [bmgp_pkg::NODE_W-1:0]   node,
    output logic [bmgp_pkg::NODE_W-1:0]   parent,
    output logic                          reached,
    output logic                          is_start,
    output logic [bmgp_pkg::CNT_W-1:0]    expanded_count,
    output logic                          stopped_on_goal
);

    import bmgp_pkg::*;

    localparam int RW = (ROOMS > 1) ? $clog2(ROOMS) : 1;
    localparam int QW = RW + 1;
    localparam int ED = ROOMS * EXITS_PER_ROOM;
    localparam int EW = (ED > 1) ? $clog2(ED) : 1;
    localparam int DW = (EXITS_PER_ROOM > 1) ? $clog2(EXITS_PER_ROOM) : 1;
    localparam int XW = NODE_W + 1;

    logic [EW-1:0]     sweep_reg;
    logic [EW-1:0]     exit_addr_reg;
    logic [DW-1:0]     dir_reg;
    logic [RW-1:0]     cur_reg;
    logic [RW-1:0]     nx_reg;
    logic [QW-1:0]     head_reg;
    logic [QW-1:0]     tail_reg;
    logic [QW-1:0]     gcnt_reg;
    logic [NODE_W-1:0] room_reg;
    logic [NODE_W-1:0] start_reg;
    logic              room_ok_reg;
    logic [CNT_W-1:0]  exp_reg;
    logic              stop_reg;

    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [NODE_W-1:0] node_reg;
    logic [NODE_W-1:0] parent_reg;
    logic              reached_reg;
    logic              is_start_reg;
    logic [CNT_W-1:0]  exp_out_reg;
    logic              stop_out_reg;

    logic              room_ok;
    logic              dir_ok;
    logic              sweep_in_rooms;
    logic              accept_write;
    logic [QW-1:0]     gcnt_dec;
    logic              seen;
    logic              q_room;
    logic              q_reached;

    logic              ex_we;
    logic [EW-1:0]     ex_waddr;
    logic [XW-1:0]     ex_wdata;
    logic [XW-1:0]     ex_rdata;

    logic              vis_sweep;
    logic              vis_we;
    logic [RW-1:0]     vis_waddr;
    logic [RW:0]       vis_wdata;
    logic [RW-1:0]     vis_raddr;
    logic [RW:0]       vis_rdata;

    logic              q_we;
    logic [RW-1:0]     q_waddr;
    logic [RW-1:0]     q_wdata;
    logic [RW-1:0]     q_rdata;

    logic              goal_sweep;
    logic              goal_set;
    logic              goal_we;
    logic [RW-1:0]     goal_waddr;
    logic [RW-1:0]     goal_raddr;
    logic              goal_rdata;

    assign room_ok        = (32'(room) < ROOMS);
    assign dir_ok         = (32'(direction) < EXITS_PER_ROOM);
    assign sweep_in_rooms = (32'(sweep_reg) < ROOMS);
    assign accept_write   = cmd.accept && (command == CMD_WRITE_EXIT);
    assign gcnt_dec       = (gcnt_reg != '0) ? (gcnt_reg - QW'(1)) : '0;
    assign seen           = vis_rdata[RW];
    assign q_room         = (tail_reg < QW'(ROOMS));

    // exit table
    assign ex_we    = cmd.sweep_clr || (accept_write && room_ok && dir_ok);
    assign ex_waddr = cmd.sweep_clr ? sweep_reg
                    : EW'(32'(room) * EXITS_PER_ROOM + 32'(direction));
    assign ex_wdata = (cmd.sweep_clr || !exit_present) ? '0 : {1'b1, target};

    bmgp_ram #(.WIDTH(XW), .DEPTH(ED)) u_exit_ram (
        .clk   (clk),
        .we    (ex_we),
        .waddr (ex_waddr),
        .wdata (ex_wdata),
        .raddr (exit_addr_reg),
        .rdata (ex_rdata)
    );

    // visited flag and parent, one word per node
    assign vis_sweep = (cmd.sweep_clr && sweep_in_rooms) || cmd.vis_clr;
    assign vis_we    = vis_sweep || (cmd.seed && room_ok_reg) || (cmd.nb_visit && !seen);
    assign vis_waddr = vis_sweep ? RW'(sweep_reg) : (cmd.seed ? RW'(start_reg) : nx_reg);
    assign vis_wdata = vis_sweep ? '0 : (cmd.seed ? {1'b1, {RW{1'b0}}} : {1'b1, cur_reg});
    assign vis_raddr = cmd.accept ? RW'(room) : RW'(ex_rdata[NODE_W-1:0]);

    bmgp_ram #(.WIDTH(RW + 1), .DEPTH(ROOMS)) u_vis_ram (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    // frontier queue
    assign q_we    = (cmd.seed && room_ok_reg) || (cmd.nb_visit && !seen && q_room);
    assign q_waddr = cmd.seed ? '0 : tail_reg[RW-1:0];
    assign q_wdata = cmd.seed ? RW'(start_reg) : nx_reg;

    bmgp_ram #(.WIDTH(RW), .DEPTH(ROOMS)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (head_reg[RW-1:0]),
        .rdata (q_rdata)
    );

    // goal set
    assign goal_sweep = cmd.sweep_clr && sweep_in_rooms;
    assign goal_set   = cmd.goal_add && room_ok_reg && !goal_rdata;
    assign goal_we    = goal_sweep || goal_set || cmd.goal_take;
    assign goal_waddr = goal_sweep ? RW'(sweep_reg) : (cmd.goal_add ? RW'(room_reg) : cur_reg);
    assign goal_raddr = cmd.accept ? RW'(room) : q_rdata;

    bmgp_ram #(.WIDTH(1), .DEPTH(ROOMS)) u_goal_ram (
        .clk   (clk),
        .we    (goal_we),
        .waddr (goal_waddr),
        .wdata (goal_set),
        .raddr (goal_raddr),
        .rdata (goal_rdata)
    );

    assign sts.cmd_code   = command;
    assign sts.sweep_last = (sweep_reg == EW'(ED - 1));
    assign sts.vis_last   = (sweep_reg == EW'(ROOMS - 1));
    assign sts.q_empty    = (head_reg == tail_reg);
    assign sts.goal_hit   = goal_rdata;
    assign sts.goal_stop  = (gcnt_dec == '0) || !mode;
    assign sts.exit_ok    = ex_rdata[NODE_W] && (32'(ex_rdata[NODE_W-1:0]) < ROOMS);
    assign sts.dir_last   = (dir_reg == DW'(EXITS_PER_ROOM - 1));
    assign sts.out_full   = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            gcnt_reg  <= '0;
            exp_reg   <= '0;
            stop_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                sweep_reg <= '0;
            end
            else if (cmd.sweep_clr || cmd.vis_clr)
            begin
                sweep_reg <= sweep_reg + EW'(1);
            end
            if (cmd.seed)
            begin
                head_reg <= '0;
                tail_reg <= room_ok_reg ? QW'(1) : '0;
                exp_reg  <= '0;
                stop_reg <= 1'b0;
            end
            if (cmd.deq)
            begin
                head_reg <= head_reg + QW'(1);
            end
            if (cmd.nb_visit && !seen && q_room)
            begin
                tail_reg <= tail_reg + QW'(1);
            end
            if (goal_set)
            begin
                gcnt_reg <= gcnt_reg + QW'(1);
            end
            if (cmd.goal_take)
            begin
                gcnt_reg <= gcnt_dec;
                if (sts.goal_stop)
                begin
                    stop_reg <= 1'b1;
                end
            end
            if (cmd.dir_adv && sts.dir_last)
            begin
                exp_reg <= exp_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            room_reg    <= room;
            room_ok_reg <= room_ok;
            if (command == CMD_SEARCH)
            begin
                start_reg <= room;
            end
        end
        if (cmd.cur_load)
        begin
            cur_reg <= q_rdata;
        end
        if (cmd.exit_start)
        begin
            exit_addr_reg <= EW'(32'(cur_reg) * EXITS_PER_ROOM);
            dir_reg       <= '0;
        end
        else if (cmd.dir_adv && !sts.dir_last)
        begin
            exit_addr_reg <= exit_addr_reg + EW'(1);
            dir_reg       <= dir_reg + DW'(1);
        end
        if (cmd.nb_rd)
        begin
            nx_reg <= RW'(ex_rdata[NODE_W-1:0]);
        end
    end

    // result register
    assign q_reached = room_ok_reg && vis_rdata[RW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept_write || cmd.goal_add || cmd.out_search || cmd.out_query)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_write || cmd.goal_add)
        begin
            status_reg   <= STAT_ACK;
            node_reg     <= accept_write ? room : room_reg;
            parent_reg   <= '0;
            reached_reg  <= 1'b0;
            is_start_reg <= 1'b0;
            exp_out_reg  <= '0;
            stop_out_reg <= 1'b0;
        end
        else if (cmd.out_search || cmd.out_query)
        begin
            status_reg   <= cmd.out_query ? STAT_QUERY : STAT_SEARCH;
            node_reg     <= room_reg;
            parent_reg   <= (cmd.out_query && q_reached) ? NODE_W'(vis_rdata[RW-1:0]) : '0;
            reached_reg  <= cmd.out_query && q_reached;
            is_start_reg <= cmd.out_query && q_reached && (room_reg == start_reg);
            exp_out_reg  <= exp_reg;
            stop_out_reg <= stop_reg;
        end
    end

    assign result_valid    = out_valid_reg;
    assign status          = status_reg;
    assign node            = node_reg;
    assign parent          = parent_reg;
    assign reached         = reached_reg;
    assign is_start        = is_start_reg;
    assign expanded_count  = exp_out_reg;
    assign stopped_on_goal = stop_out_reg;

endmodule

>>> sv/bfs_multi_goal_paths.sv
// Breadth-first search engine with a parent tree and goal removal.
// Item channel (item_valid / item_stall) carries one transaction per command:
// write exit, add goal, run search or query node. Result channel
// (result_valid / result_stall) returns exactly one transaction per item.
// A search first clears the visited store, then for each dequeued node reads
// every exit slot and checks the visited flag of each present exit whose
// target is in range; the exit table and visited store each have a single
// read port and are walked by the sequencer.
// One item is in flight at a time; item_stall is high while a command is in
// progress or while a finished result waits in the output register.
// When the receiver stalls, the result register holds its transaction and
// no new item is taken until it is drained.
// After reset a clearing pass over the ROOMS*EXITS_PER_ROOM exit entries empties the
// exit table, visited store and goal set; item_stall is high throughout,
// while APB writes to the goal-mode register (address 0) are accepted as ever.
module bfs_multi_goal_paths #(
    parameter int ROOMS          = 1024,
    parameter int EXITS_PER_ROOM = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [bmgp_pkg::CMD_W-1:0]    command,
    input  logic [bmgp_pkg::NODE_W-1:0]   room,
    input  logic [bmgp_pkg::DIR_W-1:0]    direction,
    input  logic [bmgp_pkg::NODE_W-1:0]   target,
    input  logic                          exit_present,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [bmgp_pkg::STAT_W-1:0]   status,
    output logic [bmgp_pkg::NODE_W-1:0]   node,
    output logic [bmgp_pkg::NODE_W-1:0]   parent,
    output logic                          reached,
    output logic                          is_start,
    output logic [bmgp_pkg::CNT_W-1:0]    expanded_count,
    output logic                          stopped_on_goal,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    import bmgp_pkg::*;

    bmgp_cmd_t cmd;
    bmgp_sts_t sts;
    logic      mode_reg;

    // Single register: goal mode at byte address 0.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'b0, mode_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
        begin
            mode_reg <= pwdata[0];
        end
    end

    // Sequencer: decodes items and steps the search.
    bmgp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .sts        (sts),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    // Stores, queue pointers, counters and the result register.
    bmgp_datapath #(
        .ROOMS          (ROOMS),
        .EXITS_PER_ROOM (EXITS_PER_ROOM)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .mode            (mode_reg),
        .command         (command),
        .room            (room),
        .direction       (direction),
        .target          (target),
        .exit_present    (exit_present),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .status          (status),
        .node            (node),
        .parent          (parent),
        .reached         (reached),
        .is_start        (is_start),
        .expanded_count  (expanded_count),
        .stopped_on_goal (stopped_on_goal)
    );

endmodule

>>> sv/bmgp_checker.sv
`include "bfs_multi_goal_paths_defines.svh"

module bmgp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_stall,
    input logic                          result_valid,
    input logic                          result_stall,
    input logic [bmgp_pkg::STAT_W-1:0]   status,
    input logic [bmgp_pkg::NODE_W-1:0]   parent,
    input logic                          reached,
    input logic                          is_start
);

    import bmgp_pkg::*;

    // One transaction at a time: the block is busy right after taking one.
    `BMGP_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall)

    `BMGP_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid)

    // Only query answers carry parent or reached information.
    `BMGP_ASSERT_IMP(a_nonquery_clean, result_valid && (status != STAT_QUERY), !reached && !is_start && (parent == '0))

    // The start node is always reached and has parent zero.
    `BMGP_ASSERT_IMP(a_start_root, result_valid && is_start, reached && (parent == '0))

endmodule

bind bfs_multi_goal_paths bmgp_checker u_bmgp_checker (.*);
